[sv/pbe_pkg.sv]
// ---------------------------------------------------------------------------
// pbe_pkg: shared types and constants for the PCI bus 0 enumerator
// Result kinds, read phases, config offsets and the result record.
// ---------------------------------------------------------------------------
package pbe_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int CAP_W       = 7;
	// entry count never passes the capacity, which fits the register width
	localparam int CNT_W       = CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [15:0] VENDOR_NONE = 16'hffff;
	localparam int          HDR_MF_BIT  = 7;
	localparam logic [4:0]  LAST_DEV    = 5'd31;
	localparam logic [2:0]  LAST_FN     = 3'd7;

	localparam logic [3:0] OFF_IDENT = 4'd0;
	localparam logic [3:0] OFF_CLASS = 4'd8;
	localparam logic [3:0] OFF_HDR   = 4'd12;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;

	typedef enum logic [1:0] {
		K_REQ   = 2'd0,
		K_ENTRY = 2'd1,
		K_OK    = 2'd2,
		K_FAIL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDENT = 2'd0,
		PH_CLASS = 2'd1,
		PH_HDR   = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  dev_number;
		logic [2:0]  fn_number;
		logic [3:0]  reg_offset;
		logic [15:0] vendor_code;
		logic [15:0] device_code;
		logic [7:0]  revision;
		logic [7:0]  prog_interface;
		logic [7:0]  sub_class;
		logic [7:0]  base_class;
		logic [7:0]  header_kind;
		logic        last;
	} result_t;

endpackage

[sv/pci_bus0_enumerator.sv]
// ---------------------------------------------------------------------------
// pci_bus0_enumerator: brute-force configuration scan of PCI bus 0
// Issues identity/class/header read requests and emits inventory entries.
// ---------------------------------------------------------------------------
// Results: results of an accepted transaction are written into the result queue
//   and leave on the master side from its head, in order; a transaction that
//   causes two results writes both into the queue together.
// Throughput: one transaction per cycle; the 4-entry result queue takes a new
//   transaction while it has room for two results.
// Reset: arst_n low clears the scan state and the queue at once and loads the
//   capacity register with 64.
module pci_bus0_enumerator
	import pbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration: entry capacity
	input  logic             cfg_wen,
	input  logic [CAP_W-1:0] cfg_wdata,
	// slave side
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // read_data[31:0]
	input  logic             s_tuser,   // func: 0 start scan, 1 read data
	// master side
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [87:0]      m_tdata,   // dev_number[4:0], fn_number[7:5],
	                                    // reg_offset[11:8], vendor_code[27:12],
	                                    // device_code[43:28], revision[51:44],
	                                    // prog_interface[59:52], sub_class[67:60],
	                                    // base_class[75:68], header_kind[83:76],
	                                    // zero fill [87:84]
	output logic [1:0]       m_tuser,   // kind[1:0]
	output logic             m_tlast    // last result of the input transaction
);

	// ---------------- state ----------------
	logic [CAP_W-1:0] cap_q;
	logic             scanning_q, scanning_n;
	phase_t           phase_q, phase_n;
	logic [4:0]       dev_q, dev_n;
	logic [2:0]       fn_q, fn_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]      ident_q, ident_n;
	logic [31:0]      class_q, class_n;

	// result queue
	result_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_AW:0]   oq_cnt_q;

	logic accept, pop;
	assign accept = s_tvalid && s_tready;
	assign pop    = m_tvalid && m_tready;

	// ---------------- shared decode ----------------
	logic [CAP_W-1:0] eff_cap;
	logic             id_absent, inv_full, probe_more, fn_step, dev_end;
	logic [7:0]       hdr;

	always_comb begin
		eff_cap   = (cap_q > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : cap_q;
		hdr       = s_tdata[23:16];
		id_absent = (s_tdata[15:0] == VENDOR_NONE);
		inv_full  = (cnt_q >= eff_cap);
		// other functions are probed after a header read of a multifunction
		// function 0, or when already past function 0
		if (phase_q == PH_HDR)
			probe_more = (fn_q != 3'd0) || hdr[HDR_MF_BIT];
		else
			probe_more = (fn_q != 3'd0);
		fn_step = probe_more && (fn_q != LAST_FN);
		dev_end = (dev_q == LAST_DEV);
	end

	// ---------------- next state ----------------
	always_comb begin
		scanning_n = scanning_q;
		phase_n    = phase_q;
		dev_n      = dev_q;
		fn_n       = fn_q;
		cnt_n      = cnt_q;
		ident_n    = ident_q;
		class_n    = class_q;
		if (accept) begin
			if (!s_tuser) begin
				dev_n      = 5'd0;
				fn_n       = 3'd0;
				phase_n    = PH_IDENT;
				cnt_n      = '0;
				scanning_n = (eff_cap != '0);
			end else if (scanning_q) begin
				case (phase_q)
					PH_CLASS: begin
						class_n = s_tdata;
						phase_n = PH_HDR;
					end
					PH_HDR: begin
						cnt_n   = cnt_q + CNT_W'(1);
						phase_n = PH_IDENT;
						if (fn_step) begin
							fn_n = fn_q + 3'd1;
						end else begin
							fn_n = 3'd0;
							if (dev_end) begin
								scanning_n = 1'b0;
								dev_n      = 5'd0;
							end else begin
								dev_n = dev_q + 5'd1;
							end
						end
					end
					default: begin
						// identity phase, also the unused phase code
						ident_n = s_tdata;
						if (id_absent) begin
							phase_n = PH_IDENT;
							if (fn_step) begin
								fn_n = fn_q + 3'd1;
							end else begin
								fn_n = 3'd0;
								if (dev_end) begin
									scanning_n = 1'b0;
									dev_n      = 5'd0;
								end else begin
									dev_n = dev_q + 5'd1;
								end
							end
						end else if (inv_full) begin
							scanning_n = 1'b0;
							phase_n    = PH_IDENT;
						end else begin
							phase_n = PH_CLASS;
						end
					end
				endcase
			end
		end
	end

	// ---------------- results ----------------
	result_t    res0, res1, adv;
	logic [1:0] n_res;

	always_comb begin
		// what moving past the current function produces
		adv = '0;
		if (fn_step) begin
			adv.kind       = K_REQ;
			adv.dev_number = dev_q;
			adv.fn_number  = fn_q + 3'd1;
			adv.reg_offset = OFF_IDENT;
		end else if (dev_end) begin
			adv.kind = K_OK;
		end else begin
			adv.kind       = K_REQ;
			adv.dev_number = dev_q + 5'd1;
			adv.reg_offset = OFF_IDENT;
		end

		res0  = '0;
		res1  = '0;
		n_res = 2'd0;
		if (!s_tuser) begin
			n_res = 2'd1;
			res0.kind = (eff_cap == '0) ? K_FAIL : K_REQ;
			res0.reg_offset = OFF_IDENT;
		end else if (scanning_q) begin
			case (phase_q)
				PH_CLASS: begin
					n_res          = 2'd1;
					res0.kind      = K_REQ;
					res0.dev_number = dev_q;
					res0.fn_number  = fn_q;
					res0.reg_offset = OFF_HDR;
				end
				PH_HDR: begin
					n_res               = 2'd2;
					res0.kind           = K_ENTRY;
					res0.dev_number     = dev_q;
					res0.fn_number      = fn_q;
					res0.vendor_code    = ident_q[15:0];
					res0.device_code    = ident_q[31:16];
					res0.revision       = class_q[7:0];
					res0.prog_interface = class_q[15:8];
					res0.sub_class      = class_q[23:16];
					res0.base_class     = class_q[31:24];
					res0.header_kind    = hdr;
					res1                = adv;
				end
				default: begin
					n_res = 2'd1;
					if (id_absent) begin
						res0 = adv;
					end else if (inv_full) begin
						res0.kind = K_FAIL;
					end else begin
						res0.kind       = K_REQ;
						res0.dev_number = dev_q;
						res0.fn_number  = fn_q;
						res0.reg_offset = OFF_CLASS;
					end
				end
			endcase
		end
		// start results carry the zero request fields apart from kind
		if (!s_tuser && (eff_cap == '0))
			res0.reg_offset = OFF_IDENT;
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAP_RESET;
			scanning_q <= 1'b0;
			phase_q    <= PH_IDENT;
			dev_q      <= 5'd0;
			fn_q       <= 3'd0;
			cnt_q      <= '0;
		end else begin
			if (cfg_wen)
				cap_q <= cfg_wdata;
			scanning_q <= scanning_n;
			phase_q    <= phase_n;
			dev_q      <= dev_n;
			fn_q       <= fn_n;
			cnt_q      <= cnt_n;
		end
	end

	// held words are written before any use
	always_ff @(posedge clk) begin
		ident_q <= ident_n;
		class_q <= class_n;
	end

	// ---------------- result queue ----------------
	logic [1:0] n_push;
	assign n_push = accept ? n_res : 2'd0;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			oq_q[wr_ptr_q] <= res0;
		if (n_push == 2'd2)
			oq_q[wr_ptr_q + OQ_AW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(n_push) - (OQ_AW+1)'(pop);
		end
	end

	// room for the worst case of two results
	assign s_tready = (oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign m_tvalid = (oq_cnt_q != '0);

	result_t head;
	assign head    = oq_q[rd_ptr_q];
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = {4'd0, head.header_kind, head.base_class, head.sub_class,
		head.prog_interface, head.revision, head.device_code, head.vendor_code,
		head.reg_offset, head.fn_number, head.dev_number};

	// ---------------- assertions ----------------
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH))
		else $error("result queue overflow");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!scanning_q |-> (phase_q == PH_IDENT))
		else $error("phase not identity while idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above maximum");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tuser) |=> (cnt_q == '0 && dev_q == 5'd0 && fn_q == 3'd0))
		else $error("start did not clear scan position");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |=> (oq_cnt_q != '0))
		else $error("transaction with results left queue empty");

endmodule

[tb/pci_bus0_enumerator_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pci_bus0_enumerator_tb: self-checking bench for the bus 0 enumerator
// Plays the host side of a configuration scan: start transactions and read
// words shaped to the pending request. The scan is tracked in the bench and
// every result transaction is checked in order. Both stream sides idle at
// random, and the receiver holds off once long enough to back up the block.
// ---------------------------------------------------------------------------
module pci_bus0_enumerator_tb
	import pbe_pkg::*;
;

	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE       = 4;     // settle time after the block drains
	localparam int REPORT_MAX   = 10;
	localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
	localparam int HOLD_CYCLES  = 80;

	// one slave-side transaction
	typedef struct packed {
		logic        is_data;   // tuser: 0 start scan, 1 read word
		logic [31:0] dword;
	} host_word_t;

	// scan progress as the bench sees it
	typedef struct packed {
		logic             scanning;
		phase_t           phase;
		logic [4:0]       dev;
		logic [2:0]       fn;
		logic [7:0]       entries;
		logic [31:0]      ident;
		logic [31:0]      cls_dword;
		logic [CAP_W-1:0] cap;
	} scan_state_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_wen   = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [87:0]      m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;

	host_word_t  host_words[$];    // transactions not yet offered
	result_t     due_results[$];   // results owed by the block, oldest first
	scan_state_t plan_state;       // scan as it will be once host_words is sent
	scan_state_t dut_state;        // scan as of the transactions accepted so far

	int absent_pct = 55;           // chance an identity read finds nothing
	int mf_pct     = 25;           // chance a header word marks multifunction

	bit in_flight = 1'b0;          // a transaction is on the slave side
	bit s_fired   = 1'b0;          // slave handshake at the last rising edge
	bit held_once = 1'b0;
	int s_gap = 0, m_gap = 0, s_quiet = 0, m_quiet = 0, hold_left = 0;
	int results_seen = 0;
	int fail_count   = 0;
	int cycles       = 0;

	pci_bus0_enumerator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// scan tracking
	// ------------------------------------------------------------------

	// capacity in effect: the register saturates at the inventory size
	function automatic logic [7:0] cap_limit(logic [CAP_W-1:0] cap);
		if (int'(cap) > MAX_ENTRIES)
			return 8'(MAX_ENTRIES);
		return 8'(cap);
	endfunction

	function automatic result_t read_req(scan_state_t st, logic [3:0] off);
		result_t r;
		r            = '0;
		r.kind       = K_REQ;
		r.dev_number = st.dev;
		r.fn_number  = st.fn;
		r.reg_offset = off;
		return r;
	endfunction

	// step past the current function; more = the device's other functions count
	function automatic result_t move_on(inout scan_state_t st, input logic more);
		result_t r;
		st.phase = PH_IDENT;
		if (more && st.fn != LAST_FN) begin
			st.fn = st.fn + 3'd1;
			r = read_req(st, OFF_IDENT);
		end else begin
			st.fn = '0;
			if (st.dev == LAST_DEV) begin
				// whole bus walked
				st.scanning = 1'b0;
				st.dev      = '0;
				r           = '0;
				r.kind      = K_OK;
			end else begin
				st.dev = st.dev + 5'd1;
				r = read_req(st, OFF_IDENT);
			end
		end
		return r;
	endfunction

	// results caused by one transaction; returns how many (0..2)
	function automatic int scan_step(inout scan_state_t st, input host_word_t w,
			output result_t r0, output result_t r1);
		int         n;
		logic [7:0] hdr;
		r0 = '0;
		r1 = '0;
		n  = 0;
		if (!w.is_data) begin
			// start (or restart) from device 0 with an empty inventory
			st.dev     = '0;
			st.fn      = '0;
			st.phase   = PH_IDENT;
			st.entries = '0;
			if (cap_limit(st.cap) == 8'd0) begin
				st.scanning = 1'b0;
				r0.kind     = K_FAIL;
			end else begin
				st.scanning = 1'b1;
				r0 = read_req(st, OFF_IDENT);
			end
			n = 1;
		end else if (st.scanning) begin
			case (st.phase)
				PH_CLASS: begin
					st.cls_dword = w.dword;
					st.phase     = PH_HDR;
					r0 = read_req(st, OFF_HDR);
					n  = 1;
				end
				PH_HDR: begin
					hdr               = w.dword[23:16];
					r0.kind           = K_ENTRY;
					r0.dev_number     = st.dev;
					r0.fn_number      = st.fn;
					r0.vendor_code    = st.ident[15:0];
					r0.device_code    = st.ident[31:16];
					r0.revision       = st.cls_dword[7:0];
					r0.prog_interface = st.cls_dword[15:8];
					r0.sub_class      = st.cls_dword[23:16];
					r0.base_class     = st.cls_dword[31:24];
					r0.header_kind    = hdr;
					st.entries        = st.entries + 8'd1;
					// functions past 0 are probed only on a multifunction device
					r1 = move_on(st, st.fn != '0 || hdr[HDR_MF_BIT]);
					n  = 2;
				end
				default: begin
					st.ident = w.dword;
					if (w.dword[15:0] == VENDOR_NONE) begin
						r0 = move_on(st, st.fn != '0);
					end else if (st.entries >= cap_limit(st.cap)) begin
						// inventory full on a present function
						st.scanning = 1'b0;
						st.phase    = PH_IDENT;
						r0.kind     = K_FAIL;
					end else begin
						st.phase = PH_CLASS;
						r0 = read_req(st, OFF_CLASS);
					end
					n = 1;
				end
			endcase
		end
		// read data with no scan running is dropped
		if (n == 1)
			r0.last = 1'b1;
		else if (n == 2)
			r1.last = 1'b1;
		return n;
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// queue one transaction; returns the number of results it will cause
	function automatic int send(input logic is_data, input logic [31:0] dword);
		host_word_t w;
		result_t    r0, r1;
		w.is_data = is_data;
		w.dword   = dword;
		host_words.push_back(w);
		return scan_step(plan_state, w, r0, r1);
	endfunction

	// a read word shaped to what the scan is waiting for, with some noise
	function automatic int send_random();
		logic [31:0] dword;
		int          roll;
		dword = $urandom;
		roll  = $urandom_range(0, 999);
		if (!plan_state.scanning)
			return send(roll < 80, dword);     // a stray read word now and then
		if (roll < 2)
			return send(1'b0, dword);          // restart in the middle of a scan
		if (roll < 32)
			return send(1'b1, dword);          // unshaped word
		case (plan_state.phase)
			PH_HDR:   dword[16 + HDR_MF_BIT] = ($urandom_range(0, 99) < mf_pct);
			PH_CLASS: ;
			default: begin
				if ($urandom_range(0, 99) < absent_pct)
					dword[15:0] = VENDOR_NONE;
				else if (dword[15:0] == VENDOR_NONE)
					dword[0] = 1'b0;
			end
		endcase
		return send(1'b1, dword);
	endfunction

	// block idle: everything sent, every result back, short settle
	task automatic wait_drained();
		while (host_words.size() != 0 || in_flight || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_wen        <= 1'b0;
		plan_state.cap  = cap;
		dut_state.cap   = cap;
	endtask

	initial begin
		int               sent;
		int               ph;
		int               budget;
		int               phase_items;
		logic [CAP_W-1:0] cap;
		logic             dense;
		plan_state     = '0;
		plan_state.cap = CAP_RESET;
		dut_state      = plan_state;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset capacity
		void'(send(1'b1, 32'h0000_0000));   // read word with no scan: dropped
		void'(send(1'b0, 32'hffff_ffff));   // start
		void'(send(1'b1, 32'hffff_ffff));   // dev 0 absent
		void'(send(1'b1, 32'h0000_0000));   // dev 1 present, vendor 0
		void'(send(1'b1, 32'hffff_ffff));   // class all ones
		void'(send(1'b1, 32'h0080_0000));   // header multifunction
		void'(send(1'b1, 32'h1234_ffff));   // fn 1 absent, probing goes on
		void'(send(1'b1, 32'hbeef_8086));   // fn 2 present
		void'(send(1'b1, 32'h0000_0000));   // class zero
		void'(send(1'b1, 32'hff7f_ffff));   // header without the flag, fn 3 next
		void'(send(1'b0, 32'h5a5a_5a5a));   // restart while scanning
		void'(send(1'b1, 32'hfffe_0001));   // dev 0 present
		void'(send(1'b1, $urandom));
		void'(send(1'b1, 32'h007f_0000));   // single function: on to dev 1

		// directed: zero capacity fails at once
		write_capacity('0);
		void'(send(1'b0, $urandom));
		void'(send(1'b1, $urandom));        // still idle: dropped

		// directed: capacity 1 runs out on the second function
		write_capacity(CAP_W'(1));
		void'(send(1'b0, $urandom));
		void'(send(1'b1, 32'h1234_5678));
		void'(send(1'b1, $urandom));
		void'(send(1'b1, 32'h0080_0000));
		void'(send(1'b1, 32'h0001_0002));

		// random phases, one capacity each; dense phases fill the inventory
		sent = 0;
		ph   = 0;
		while (sent < RANDOM_ITEMS) begin
			case (ph)
				0:       cap = CAP_W'(1);
				1:       cap = '1;
				2:       cap = CAP_W'(3);
				3:       cap = CAP_W'(MAX_ENTRIES);
				4:       cap = '0;
				default: cap = CAP_W'($urandom_range(0, 127));
			endcase
			dense      = (ph == 1 || ph == 3);
			absent_pct = dense ? 10 : 55;
			mf_pct     = dense ? 80 : 25;
			budget     = (cap == '0) ? 10 : (dense ? 260 : 110);
			write_capacity(cap);
			phase_items = 0;
			while (phase_items < budget) begin
				if (send_random() != 0)
					phase_items++;
			end
			sent += phase_items;
			ph++;
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && due_results.size() == 0)
			$display("pci_bus0_enumerator verification clean");
		else
			$display("pci_bus0_enumerator verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// slave-side driver: one transaction at a time, gaps between them
	// ------------------------------------------------------------------
	always @(negedge clk) begin : host_drive
		host_word_t w;
		if (arst_n) begin
			if (s_fired)
				in_flight = 1'b0;
			// quiet stretches: no gaps at all for a while
			if (s_quiet > 0)
				s_quiet--;
			else if ($urandom_range(0, 399) == 0)
				s_quiet = $urandom_range(100, 300);
			if (!in_flight) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (host_words.size() != 0) begin
					w = host_words.pop_front();
					in_flight = 1'b1;
					s_tvalid <= 1'b1;
					s_tuser  <= w.is_data;
					s_tdata  <= w.dword;
					s_gap     = (s_quiet > 0) ? 0 : idle_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// master-side ready: random stalls plus one long hold-off that lets
	// the result queue fill and push back on the slave side
	// ------------------------------------------------------------------
	always @(negedge clk) begin : sink_drive
		if (arst_n) begin
			if (m_quiet > 0)
				m_quiet--;
			else if ($urandom_range(0, 399) == 0)
				m_quiet = $urandom_range(100, 300);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held_once && results_seen >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (m_gap > 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_quiet == 0 && $urandom_range(0, 3) == 0)
					m_gap = idle_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	function automatic string show(result_t r);
		return $sformatf({"kind=%0d dev=%0d fn=%0d off=%0d ven=%h did=%h rev=%h",
			" pi=%h sub=%h base=%h hdr=%h last=%b"},
			r.kind, r.dev_number, r.fn_number, r.reg_offset, r.vendor_code,
			r.device_code, r.revision, r.prog_interface, r.sub_class,
			r.base_class, r.header_kind, r.last);
	endfunction

	function automatic string field_diffs(result_t a, result_t b);
		string s;
		s = "";
		if (a.kind !== b.kind)                     s = {s, " kind"};
		if (a.dev_number !== b.dev_number)         s = {s, " dev_number"};
		if (a.fn_number !== b.fn_number)           s = {s, " fn_number"};
		if (a.reg_offset !== b.reg_offset)         s = {s, " reg_offset"};
		if (a.vendor_code !== b.vendor_code)       s = {s, " vendor_code"};
		if (a.device_code !== b.device_code)       s = {s, " device_code"};
		if (a.revision !== b.revision)             s = {s, " revision"};
		if (a.prog_interface !== b.prog_interface) s = {s, " prog_interface"};
		if (a.sub_class !== b.sub_class)           s = {s, " sub_class"};
		if (a.base_class !== b.base_class)         s = {s, " base_class"};
		if (a.header_kind !== b.header_kind)       s = {s, " header_kind"};
		if (a.last !== b.last)                     s = {s, " last"};
		return s;
	endfunction

	always @(posedge clk) begin : watch
		result_t    got, want, r0, r1;
		host_word_t w;
		string      bad;
		int         n;
		if (arst_n) begin
			// result side first: nothing accepted now can be answered this edge
			if (m_tvalid && m_tready) begin
				got                = '0;
				got.kind           = kind_t'(m_tuser);
				got.dev_number     = m_tdata[4:0];
				got.fn_number      = m_tdata[7:5];
				got.reg_offset     = m_tdata[11:8];
				got.vendor_code    = m_tdata[27:12];
				got.device_code    = m_tdata[43:28];
				got.revision       = m_tdata[51:44];
				got.prog_interface = m_tdata[59:52];
				got.sub_class      = m_tdata[67:60];
				got.base_class     = m_tdata[75:68];
				got.header_kind    = m_tdata[83:76];
				got.last           = m_tlast;
				results_seen++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: result with none owed: %s", $realtime, show(got));
				end else begin
					want = due_results.pop_front();
					bad  = field_diffs(want, got);
					if (bad != "") begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
								$realtime, bad, show(want), show(got));
					end
				end
			end
			s_fired = s_tvalid && s_tready;
			if (s_fired) begin
				w.is_data = s_tuser;
				w.dword   = s_tdata;
				n = scan_step(dut_state, w, r0, r1);
				if (n > 0)
					due_results.push_back(r0);
				if (n > 1)
					due_results.push_back(r1);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("pci_bus0_enumerator verification failed");
			$finish;
		end
	end

endmodule
